>>> rtl/frs_pkg.sv
// Shared constants, sideband structs and rounding helper for the Schlick
// Fresnel reflectance pipeline. No dependencies.
package frs_pkg;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Divider and square root widths
  localparam int NUM_A_W   = 49;  // d^2 << 17
  localparam int DEN_A_W   = 34;  // (from + to)^2
  localparam int NUM_B_W   = 49;  // from^2 * (1 - c^2)
  localparam int DEN_B_W   = 32;  // to^2
  localparam int QUOT_W    = 18;
  localparam int SQRT_IN_W = 34;
  localparam int ROOT_W    = 17;

  // Front end result handed to the two dividers
  typedef struct packed {
    logic [NUM_A_W-1:0] num_a;
    logic [DEN_A_W-1:0] den_a;
    logic [NUM_B_W-1:0] num_b;
    logic [DEN_B_W-1:0] den_b;
    logic [16:0]        c;
    logic               dense;
    logic               tir;
    logic [16:0]        base;
  } front_t;

  // Carried alongside the sin^2 divider
  typedef struct packed {
    logic [16:0] c;
    logic        dense;
    logic        tir;
    logic [16:0] base;
    logic        den_zero;
  } div_side_t;

  // Carried alongside the square root and into the shading stages
  typedef struct packed {
    logic [16:0] r0;
    logic [16:0] c;
    logic        dense;
    logic        tir;
    logic [16:0] base;
  } shade_side_t;

  // Round a Q2.32 product to Q1.16
  function automatic logic [16:0] rnd16(input logic [33:0] v);
    logic [34:0] t;
    t = {1'b0, v} + 35'd32768;
    return t[32:16];
  endfunction

endpackage

>>> rtl/fresnel_reflectance_schlick.sv
// Schlick Fresnel reflectance, fully pipelined.
// Pipeline: a result is presented after its transaction passes 7 front stages,
// 18 divider stages, 1 select stage, 17 root stages and 6 shading stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// result waits, and the output register frees ready as soon as it is taken.
// Reset: synchronous, clears every stage valid bit; payload is not reset.
module fresnel_reflectance_schlick
  import frs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [15:0]        index_from,
  input  logic [15:0]        index_to,
  input  logic signed [15:0] incident_x,
  input  logic signed [15:0] incident_y,
  input  logic signed [15:0] incident_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [16:0]        base_reflect,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [16:0]        reflectance,
  output logic               total_internal
);

  logic              en;
  logic              front_valid;
  front_t            front_data;
  logic              div_a_valid, div_b_valid;
  logic [QUOT_W-1:0] quot_a, quot_b;
  logic              s_zero;
  div_side_t         side_b_in, side_b_out;
  logic              sel_valid;
  logic [SQRT_IN_W-1:0] sel_radicand;
  shade_side_t       sel_side;
  logic              root_valid;
  logic [ROOT_W-1:0] root;
  shade_side_t       root_side;
  logic [QUOT_W:0]   r0_round;
  logic [16:0]       r0;
  logic [16:0]       sin2;

  // Hold every stage while the output waits
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  frs_front u_front (
    .clk, .rst, .en,
    .in_valid (item_valid),
    .index_from, .index_to,
    .incident_x, .incident_y, .incident_z,
    .normal_x, .normal_y, .normal_z,
    .base_reflect,
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  // r0 quotient, doubled for round-half-up
  frs_divider #(
    .NUM_W (NUM_A_W), .DEN_W (DEN_A_W), .Q_W (QUOT_W), .SIDE_W (1)
  ) u_div_r0 (
    .clk, .rst, .en,
    .in_valid  (front_valid),
    .num       (front_data.num_a),
    .den       (front_data.den_a),
    .side      (front_data.den_a == '0),
    .out_valid (div_a_valid),
    .quot      (quot_a),
    .out_side  (s_zero)
  );

  assign side_b_in = '{c:        front_data.c,
                       dense:    front_data.dense,
                       tir:      front_data.tir,
                       base:     front_data.base,
                       den_zero: front_data.den_b == '0};

  // Transmitted squared sine
  frs_divider #(
    .NUM_W (NUM_B_W), .DEN_W (DEN_B_W), .Q_W (QUOT_W), .SIDE_W ($bits(div_side_t))
  ) u_div_sin2 (
    .clk, .rst, .en,
    .in_valid  (front_valid),
    .num       (front_data.num_b),
    .den       (front_data.den_b),
    .side      (side_b_in),
    .out_valid (div_b_valid),
    .quot      (quot_b),
    .out_side  (side_b_out)
  );

  // Round and clamp r0, clamp sin^2
  always_comb begin
    r0_round = ({1'b0, quot_a} + (QUOT_W+1)'(1)) >> 1;
    if (s_zero) begin
      r0 = '0;
    end else if (r0_round > (QUOT_W+1)'(ONE_Q16)) begin
      r0 = ONE_Q16;
    end else begin
      r0 = r0_round[16:0];
    end
    if (side_b_out.den_zero) begin
      sin2 = '0;
    end else if (quot_b > QUOT_W'(ONE_Q16)) begin
      sin2 = ONE_Q16;
    end else begin
      sin2 = quot_b[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (en) begin
      sel_valid <= div_a_valid && div_b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_radicand <= SQRT_IN_W'(ONE_Q16 - sin2) << 16;
      sel_side     <= '{r0:    r0,
                        c:     side_b_out.c,
                        dense: side_b_out.dense,
                        tir:   side_b_out.tir,
                        base:  side_b_out.base};
    end
  end

  // Transmitted cosine
  frs_sqrt #(
    .V_W (SQRT_IN_W), .R_W (ROOT_W), .SIDE_W ($bits(shade_side_t))
  ) u_sqrt (
    .clk, .rst, .en,
    .in_valid  (sel_valid),
    .radicand  (sel_radicand),
    .side      (sel_side),
    .out_valid (root_valid),
    .root      (root),
    .out_side  (root_side)
  );

  frs_shade u_shade (
    .clk, .rst, .en,
    .in_valid       (root_valid),
    .root           (root),
    .side           (root_side),
    .out_valid      (result_valid),
    .reflectance    (reflectance),
    .total_internal (total_internal)
  );

endmodule

>>> rtl/frs_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing outside this file.
module frs_divider #(
  parameter int NUM_W  = 49,
  parameter int DEN_W  = 34,
  parameter int Q_W    = 18,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0]  rem  [Q_W];
  logic [DEN_W-1:0]  dsr  [Q_W];
  logic [Q_W-1:0]    qv   [Q_W];
  logic [SIDE_W-1:0] sd   [Q_W];
  logic              vld  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [NUM_W-1:0]  rem_prev;
    logic [DEN_W-1:0]  den_prev;
    logic [Q_W-1:0]    q_prev;
    logic [SIDE_W-1:0] side_prev;
    logic              valid_prev;
    logic [CMP_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_prev   = num;
      assign den_prev   = den;
      assign q_prev     = '0;
      assign side_prev  = side;
      assign valid_prev = in_valid;
    end else begin : g_next
      assign rem_prev   = rem[k-1];
      assign den_prev   = dsr[k-1];
      assign q_prev     = qv[k-1];
      assign side_prev  = sd[k-1];
      assign valid_prev = vld[k-1];
    end

    // Trial subtract of the shifted divisor
    assign trial = CMP_W'(den_prev) << (Q_W - 1 - k);
    assign take  = CMP_W'(rem_prev) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= valid_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? NUM_W'(CMP_W'(rem_prev) - trial) : rem_prev;
        dsr[k] <= den_prev;
        qv[k]  <= q_prev | (Q_W'(take) << (Q_W - 1 - k));
        sd[k]  <= side_prev;
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quot      = qv[Q_W-1];
  assign out_side  = sd[Q_W-1];

endmodule

>>> rtl/frs_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on nothing outside this file.
module frs_sqrt #(
  parameter int V_W    = 34,
  parameter int R_W    = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [V_W-1:0]    radicand,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [R_W-1:0]    root,
  output logic [SIDE_W-1:0] out_side
);

  logic [V_W-1:0]    rem [R_W];
  logic [V_W-1:0]    res [R_W];
  logic [SIDE_W-1:0] sd  [R_W];
  logic              vld [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam logic [V_W-1:0] BIT = V_W'(1) << (2 * (R_W - 1 - k));
    logic [V_W-1:0]    rem_prev;
    logic [V_W-1:0]    res_prev;
    logic [SIDE_W-1:0] side_prev;
    logic              valid_prev;
    logic [V_W:0]      sum;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_prev   = radicand;
      assign res_prev   = '0;
      assign side_prev  = side;
      assign valid_prev = in_valid;
    end else begin : g_next
      assign rem_prev   = rem[k-1];
      assign res_prev   = res[k-1];
      assign side_prev  = sd[k-1];
      assign valid_prev = vld[k-1];
    end

    // Accept the root bit if the remainder covers it
    assign sum  = {1'b0, res_prev} + {1'b0, BIT};
    assign take = {1'b0, rem_prev} >= sum;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= valid_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? V_W'({1'b0, rem_prev} - sum) : rem_prev;
        res[k] <= take ? V_W'((res_prev >> 1) + BIT) : (res_prev >> 1);
        sd[k]  <= side_prev;
      end
    end
  end

  assign out_valid = vld[R_W-1];
  assign root      = res[R_W-1][R_W-1:0];
  assign out_side  = sd[R_W-1];

endmodule

>>> rtl/frs_front.sv
// Front end: index terms, dot product, cosine, 1 - c^2 and the total
// internal reflection test over seven stages. Uses frs_pkg.
module frs_front
  import frs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [15:0]        index_from,
  input  logic [15:0]        index_to,
  input  logic signed [15:0] incident_x,
  input  logic signed [15:0] incident_y,
  input  logic signed [15:0] incident_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [16:0]        base_reflect,
  output logic               out_valid,
  output front_t             out_data
);

  logic v1, v2, v3, v4, v5, v6, v7;

  // Stage 1 registers
  logic [15:0]        f1_d;
  logic [16:0]        f1_s;
  logic               f1_dense;
  logic [16:0]        f1_base;
  logic signed [31:0] f1_px, f1_py, f1_pz;
  logic [31:0]        f1_from_sq, f1_to_sq;
  // Stage 2 registers
  logic signed [33:0] f2_dot;
  logic [31:0]        f2_d_sq;
  logic [33:0]        f2_s_sq;
  logic [31:0]        f2_from_sq, f2_to_sq;
  logic               f2_dense;
  logic [16:0]        f2_base;
  // Stage 3 registers
  logic [16:0]        f3_c;
  logic [31:0]        f3_d_sq;
  logic [33:0]        f3_s_sq;
  logic [31:0]        f3_from_sq, f3_to_sq;
  logic               f3_dense;
  logic [16:0]        f3_base;
  // Stage 4 registers
  logic [32:0]        f4_c_sq;
  logic [16:0]        f4_c;
  logic [31:0]        f4_d_sq;
  logic [33:0]        f4_s_sq;
  logic [31:0]        f4_from_sq, f4_to_sq;
  logic               f4_dense;
  logic [16:0]        f4_base;
  // Stage 5 registers
  logic [16:0]        f5_omc;
  logic [16:0]        f5_c;
  logic [31:0]        f5_d_sq;
  logic [33:0]        f5_s_sq;
  logic [31:0]        f5_from_sq, f5_to_sq;
  logic               f5_dense;
  logic [16:0]        f5_base;
  // Stage 6 registers
  logic [48:0]        f6_num;
  logic [16:0]        f6_c;
  logic [31:0]        f6_d_sq;
  logic [33:0]        f6_s_sq;
  logic [31:0]        f6_to_sq;
  logic               f6_dense;
  logic [16:0]        f6_base;

  logic signed [34:0] negdot;
  logic [22:0]        c_wide;
  logic [16:0]        c_sat;
  logic [33:0]        omc_wide;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // Saturate the cosine to 0..1
  always_comb begin
    negdot = 35'sd2048 - 35'(f2_dot);
    c_wide = negdot[34:12];
    if (negdot <= 35'sd0) begin
      c_sat = '0;
    end else if (c_wide > 23'(ONE_Q16)) begin
      c_sat = ONE_Q16;
    end else begin
      c_sat = c_wide[16:0];
    end
  end

  // Rounded 1 - c^2
  assign omc_wide = 34'd4294967296 - 34'(f4_c_sq) + 34'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: products and index terms
      f1_d       <= (index_from > index_to) ? index_from - index_to
                                            : index_to - index_from;
      f1_s       <= {1'b0, index_from} + {1'b0, index_to};
      f1_dense   <= index_from > index_to;
      f1_base    <= (base_reflect > ONE_Q16) ? ONE_Q16 : base_reflect;
      f1_px      <= normal_x * incident_x;
      f1_py      <= normal_y * incident_y;
      f1_pz      <= normal_z * incident_z;
      f1_from_sq <= index_from * index_from;
      f1_to_sq   <= index_to * index_to;
      // Stage 2: dot sum and squares
      f2_dot     <= 34'(f1_px) + 34'(f1_py) + 34'(f1_pz);
      f2_d_sq    <= f1_d * f1_d;
      f2_s_sq    <= f1_s * f1_s;
      f2_from_sq <= f1_from_sq;
      f2_to_sq   <= f1_to_sq;
      f2_dense   <= f1_dense;
      f2_base    <= f1_base;
      // Stage 3: cosine
      f3_c       <= c_sat;
      f3_d_sq    <= f2_d_sq;
      f3_s_sq    <= f2_s_sq;
      f3_from_sq <= f2_from_sq;
      f3_to_sq   <= f2_to_sq;
      f3_dense   <= f2_dense;
      f3_base    <= f2_base;
      // Stage 4: cosine squared
      f4_c_sq    <= f3_c * f3_c;
      f4_c       <= f3_c;
      f4_d_sq    <= f3_d_sq;
      f4_s_sq    <= f3_s_sq;
      f4_from_sq <= f3_from_sq;
      f4_to_sq   <= f3_to_sq;
      f4_dense   <= f3_dense;
      f4_base    <= f3_base;
      // Stage 5: 1 - c^2
      f5_omc     <= omc_wide[32:16];
      f5_c       <= f4_c;
      f5_d_sq    <= f4_d_sq;
      f5_s_sq    <= f4_s_sq;
      f5_from_sq <= f4_from_sq;
      f5_to_sq   <= f4_to_sq;
      f5_dense   <= f4_dense;
      f5_base    <= f4_base;
      // Stage 6: scaled squared sine numerator
      f6_num     <= 49'(f5_from_sq) * 49'(f5_omc);
      f6_c       <= f5_c;
      f6_d_sq    <= f5_d_sq;
      f6_s_sq    <= f5_s_sq;
      f6_to_sq   <= f5_to_sq;
      f6_dense   <= f5_dense;
      f6_base    <= f5_base;
      // Stage 7: total internal reflection test and divider operands
      out_data.num_a <= {f6_d_sq, 17'd0};
      out_data.den_a <= f6_s_sq;
      out_data.num_b <= f6_num;
      out_data.den_b <= f6_to_sq;
      out_data.c     <= f6_c;
      out_data.dense <= f6_dense;
      out_data.tir   <= f6_dense && (f6_num > {1'b0, f6_to_sq, 16'd0});
      out_data.base  <= f6_base;
    end
  end

  assign out_valid = v7;

endmodule

>>> rtl/frs_shade.sv
// Back end: (1 - c)^5, Schlick sum and base reflectance blend over six
// stages. Uses frs_pkg.
module frs_shade
  import frs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] root,
  input  shade_side_t       side,
  output logic              out_valid,
  output logic [16:0]       reflectance,
  output logic              total_internal
);

  logic v0, v1, v2, v3, v4, v5;
  logic [16:0] s0_x, s1_x, s2_x;
  logic [16:0] s1_p2, s2_p4, s3_p5, s4_schlick;
  logic [16:0] s0_r0, s1_r0, s2_r0, s3_r0;
  logic [16:0] s0_b, s1_b, s2_b, s3_b, s4_b;
  logic        s0_t, s1_t, s2_t, s3_t, s4_t;
  logic [16:0] c_fin;
  logic [17:0] schlick_sum;
  logic [17:0] res_sum;

  assign c_fin       = side.dense ? root : side.c;
  assign schlick_sum = {1'b0, s3_r0} + {1'b0, rnd16(34'(ONE_Q16 - s3_r0) * 34'(s3_p5))};
  assign res_sum     = {1'b0, s4_b} + {1'b0, rnd16(34'(ONE_Q16 - s4_b) * 34'(s4_schlick))};

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid; v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x  <= ONE_Q16 - c_fin;
      s0_r0 <= side.r0;
      s0_b  <= side.base;
      s0_t  <= side.tir;
      // Powers of 1 - c
      s1_p2 <= rnd16(34'(s0_x) * 34'(s0_x));
      s1_x  <= s0_x; s1_r0 <= s0_r0; s1_b <= s0_b; s1_t <= s0_t;
      s2_p4 <= rnd16(34'(s1_p2) * 34'(s1_p2));
      s2_x  <= s1_x; s2_r0 <= s1_r0; s2_b <= s1_b; s2_t <= s1_t;
      s3_p5 <= rnd16(34'(s2_p4) * 34'(s2_x));
      s3_r0 <= s2_r0; s3_b <= s2_b; s3_t <= s2_t;
      // Schlick sum, saturated
      s4_schlick <= (schlick_sum > 18'(ONE_Q16)) ? ONE_Q16 : schlick_sum[16:0];
      s4_b <= s3_b; s4_t <= s3_t;
      // Blend with the base, force one on total internal reflection
      if (s4_t) begin
        reflectance <= ONE_Q16;
      end else begin
        reflectance <= (res_sum > 18'(ONE_Q16)) ? ONE_Q16 : res_sum[16:0];
      end
      total_internal <= s4_t;
    end
  end

  assign out_valid = v5;

endmodule

>>> rtl/frs_checker.sv
// Port-level checks for the Schlick Fresnel pipeline, bound to the top level.
// Uses frs_pkg for the unit constant.
module frs_checker
  import frs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [16:0] reflectance,
  input logic        total_internal
);

  // A waiting result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(reflectance)
      && $stable(total_internal))
    else $error("stalled result changed");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // An empty output register never refuses a transaction
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with empty output");

  // Total internal reflection forces unit reflectance
  a_tir: assert property (@(posedge clk) disable iff (rst)
    result_valid && total_internal |-> reflectance == ONE_Q16)
    else $error("total internal reflection without unit result");

  // Reflectance stays within 0..1
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> reflectance <= ONE_Q16)
    else $error("reflectance above one");

endmodule

bind fresnel_reflectance_schlick frs_checker u_frs_checker (
  .clk            (clk),
  .rst            (rst),
  .item_ready     (item_ready),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .reflectance    (reflectance),
  .total_internal (total_internal)
);

>>> verif/frs_checker.sv
`timescale 1ns / 100ps
// Watches both channels of the Fresnel reflectance block, predicts each
// result from the accepted transaction and compares in order. Uses frs_pkg.
module frs_scoreboard
  import frs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic [15:0]        index_from,
  input  logic [15:0]        index_to,
  input  logic signed [15:0] incident_x,
  input  logic signed [15:0] incident_y,
  input  logic signed [15:0] incident_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [16:0]        base_reflect,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic [16:0]        reflectance,
  input  logic               total_internal,
  output int                 fail_count,
  output int                 pending,
  output int                 checked,
  output int                 tir_seen
);

  typedef struct packed {
    logic [16:0] refl;
    logic        tir;
  } fresnel_t;

  fresnel_t expected_q[$];

  function automatic longint unsigned round_q16(input longint unsigned v);
    return (v + 64'd32768) >> 16;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Schlick reflectance with dense-side refraction and base blend
  function automatic fresnel_t predict_fresnel(
    input logic [15:0] n_from, input logic [15:0] n_to,
    input logic signed [15:0] ix, input logic signed [15:0] iy,
    input logic signed [15:0] iz, input logic signed [15:0] nx,
    input logic signed [15:0] ny, input logic signed [15:0] nz,
    input logic [16:0] base_in);
    longint unsigned f, t, b, d, s, r0, c, x, p2, p4, p5, sch, res;
    longint unsigned omc, num, den, sin2;
    longint dot, negdot;
    fresnel_t out;
    f = n_from;
    t = n_to;
    b = (base_in > ONE_Q16) ? 64'd65536 : longint'(base_in);
    d = (f > t) ? f - t : t - f;
    s = f + t;
    if (s == 0) begin
      r0 = 0;
    end else begin
      r0 = (d * d * 64'd65536 + (s * s) / 2) / (s * s);
      if (r0 > 65536) r0 = 65536;
    end
    dot = longint'(nx) * longint'(ix) + longint'(ny) * longint'(iy)
        + longint'(nz) * longint'(iz);
    negdot = -dot + 2048;
    if (negdot <= 0) begin
      c = 0;
    end else begin
      c = longint'(negdot) >> 12;
      if (c > 65536) c = 65536;
    end
    out.tir = 1'b0;
    if (f > t) begin
      omc = round_q16((64'd1 << 32) - c * c);
      num = f * f * omc;
      den = t * t;
      if (num > den * 64'd65536) begin
        out.refl = ONE_Q16;
        out.tir = 1'b1;
        return out;
      end
      sin2 = (den != 0) ? num / den : 0;
      if (sin2 > 65536) sin2 = 65536;
      c = int_sqrt((64'd65536 - sin2) << 16);
      if (c > 65536) c = 65536;
    end
    x = 64'd65536 - c;
    p2 = round_q16(x * x);
    p4 = round_q16(p2 * p2);
    p5 = round_q16(p4 * x);
    sch = r0 + round_q16((64'd65536 - r0) * p5);
    if (sch > 65536) sch = 65536;
    res = b + round_q16((64'd65536 - b) * sch);
    if (res > 65536) res = 65536;
    out.refl = res[16:0];
    return out;
  endfunction

  assign pending = expected_q.size();

  // Record expectations on input transactions, compare on output ones
  always @(posedge clk) begin
    fresnel_t got;
    fresnel_t want;
    if (rst) begin
      fail_count <= 0;
      checked <= 0;
      tir_seen <= 0;
    end else begin
      if (item_valid && item_ready)
        expected_q.push_back(predict_fresnel(index_from, index_to, incident_x,
          incident_y, incident_z, normal_x, normal_y, normal_z, base_reflect));
      if (result_valid && result_ready) begin
        got.refl = reflectance;
        got.tir = total_internal;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: refl %0d tir %0b",
                   $time, got.refl, got.tir);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          checked <= checked + 1;
          if (want.tir) tir_seen <= tir_seen + 1;
          if (want.refl !== got.refl || want.tir !== got.tir) begin
            $display("%0t: mismatch: expected refl %0d tir %0b, actual refl %0d tir %0b",
                     $time, want.refl, want.tir, got.refl, got.tir);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/fresnel_reflectance_schlick_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the Schlick Fresnel reflectance block. Depends on
// frs_pkg, the block itself and the frs_scoreboard module.
module fresnel_reflectance_schlick_tb
  import frs_pkg::*;
;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic [15:0]        index_from = 16'd4096;
  logic [15:0]        index_to = 16'd4096;
  logic signed [15:0] incident_x = '0;
  logic signed [15:0] incident_y = '0;
  logic signed [15:0] incident_z = '0;
  logic signed [15:0] normal_x = '0;
  logic signed [15:0] normal_y = '0;
  logic signed [15:0] normal_z = '0;
  logic [16:0]        base_reflect = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [16:0]        reflectance;
  logic               total_internal;

  int fail_count, pending, checked, tir_seen;
  int sent = 0;
  int cycles = 0;
  int burst_left = 0;

  always #6 clk = ~clk;

  fresnel_reflectance_schlick DUT (.*);

  frs_scoreboard checker_i (.*);

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stall the result side, switching among always ready, mostly ready, a repeating pattern and mostly stalled
  always @(posedge clk) begin
    case ((cycles / 300) % 4)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 9) < 7);
      2: result_ready <= ((cycles % 7) < 3);
      default: result_ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  // Present one transaction and hold it until accepted, then maybe gap
  task automatic send_item(input logic [15:0] nf, input logic [15:0] nt,
                           input logic signed [15:0] ix,
                           input logic signed [15:0] iy,
                           input logic signed [15:0] iz,
                           input logic signed [15:0] nx,
                           input logic signed [15:0] ny,
                           input logic signed [15:0] nz,
                           input logic [16:0] b);
    int gap;
    item_valid <= 1'b1;
    index_from <= nf;
    index_to <= nt;
    incident_x <= ix;
    incident_y <= iy;
    incident_z <= iz;
    normal_x <= nx;
    normal_y <= ny;
    normal_z <= nz;
    base_reflect <= b;
    do @(posedge clk); while (!item_ready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Unit incident direction at a random angle to a random axis normal
  task automatic send_unit(input logic [15:0] nf, input logic [15:0] nt,
                           input logic [16:0] b);
    real theta, sn, cs;
    logic signed [15:0] v[3];
    logic signed [15:0] n[3];
    int ax, sg;
    theta = $urandom_range(0, 100000) * 1.5707963 / 100000.0;
    if ($urandom_range(0, 7) == 0) theta = theta + 1.5707963;
    sn = $sin(theta) * 16384.0;
    cs = $cos(theta) * 16384.0;
    ax = $urandom_range(0, 2);
    sg = $urandom_range(0, 1) ? 1 : -1;
    for (int k = 0; k < 3; k++) begin
      v[k] = '0;
      n[k] = '0;
    end
    n[ax] = 16'(sg * 16384);
    v[ax] = 16'($rtoi(-sg * cs));
    v[(ax + 1) % 3] = 16'($rtoi(sn) * ($urandom_range(0, 1) ? 1 : -1));
    send_item(nf, nt, v[0], v[1], v[2], n[0], n[1], n[2], b);
  endtask

  function automatic logic [15:0] pick_index();
    case ($urandom_range(0, 19))
      0: return 16'($urandom_range(0, 4095));
      1: return 16'hFFFF;
      2: return 16'd4096;
      default: return 16'($urandom_range(4096, 8192));
    endcase
  endfunction

  function automatic logic [16:0] pick_base();
    case ($urandom_range(0, 9))
      0: return 17'($urandom_range(65536, 131071));
      1: return 17'd0;
      2: return ONE_Q16;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: head-on, grazing, extremes of indices and base
    send_item(16'd4096, 16'd6144, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
              16'sd16384, 17'd0);
    send_item(16'd4096, 16'd6144, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
              16'sd16384, 17'd0);
    send_item(16'd6144, 16'd4096, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
              16'sd16384, 17'd1000);
    // Total internal reflection at grazing from the dense side
    send_item(16'd6144, 16'd4096, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
              16'sd16384, 17'd5000);
    send_item(16'hFFFF, 16'd4096, 16'sd11585, 16'sd0, -16'sd11585, 16'sd0,
              16'sd0, 16'sd16384, 17'd0);
    // Cosine below zero and above one
    send_item(16'd4096, 16'd8192, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
              16'sd16384, 17'd0);
    send_item(16'd4096, 16'd8192, -16'sd32768, -16'sd32768, -16'sd32768,
              -16'sd32768, -16'sd32768, -16'sd32768, 17'd0);
    send_item(16'd4096, 16'd8192, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              -16'sd32768, -16'sd32768, -16'sd32768, 17'd100);
    // Base reflectance at one and above one
    send_item(16'd4096, 16'd4096, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
              16'sd16384, 16'sd0, ONE_Q16);
    send_item(16'd4096, 16'd4096, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
              16'sd16384, 16'sd0, 17'h1FFFF);
    // Both indices zero, entered index zero, then extreme index pairs
    send_item(16'd0, 16'd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
              16'sd16384, 17'd0);
    send_item(16'd4096, 16'd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
              16'sd16384, 17'd0);
    send_item(16'd4096, 16'd0, 16'sd0, 16'sd8000, -16'sd12000, 16'sd0, 16'sd0,
              16'sd16384, 17'd0);
    send_item(16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
              16'sd0, 17'd32768);
    send_item(16'hFFFF, 16'd1, 16'sd100, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
              16'sd16384, 17'd0);
    send_item(16'd1, 16'hFFFF, 16'sh7FFF, -16'sd32768, 16'sh7FFF, -16'sd32768,
              16'sh7FFF, -16'sd32768, 17'h10000);

    // Random: mostly unit vectors, some raw noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 9) < 8)
        send_unit(pick_index(), pick_index(), pick_base());
      else
        send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  17'($urandom));
    end
    item_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results, %0d total internal.",
             sent, checked, tir_seen);
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
